### hdl/fdw_pkg.sv
// ----------------------------------------------------------------------------
// fdw_pkg
// Shared widths, register indexes and the write word type of the frame
// damage diff write emitter.
// ----------------------------------------------------------------------------
package fdw_pkg;

   localparam int PIXEL_W        = 32;
   localparam int ADDR_W         = 32;
   localparam int FRAME_PIXELS_W = 21;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 32;

   localparam logic [FRAME_PIXELS_W-1:0] FRAME_PIXELS_RESET = 21'd786432;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_BASE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_PIXELS = 2'd1;

   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = 2;
   localparam int QUEUE_LEVEL_W = 3;

   typedef struct packed {
      logic [ADDR_W-1:0]  write_address;
      logic [PIXEL_W-1:0] pixel_value;
      logic               run_start;
   } fdw_write_type;

endpackage

### hdl/frame_diff_write_emitter.sv
// ----------------------------------------------------------------------------
// frame_diff_write_emitter
// Compares a streamed frame against the last shown frame and emits one
// framebuffer write for each changed pixel.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while req_stall is low, in raster order. A pixel
// is looked up in the shown-frame store in the cycle it is accepted and
// compared and written back in the next, then its write word is queued for
// rsp_valid; the store's one read and one write per cycle set the rate.
// A four-word queue absorbs result stalls; req_stall rises only when that
// queue, plus the pixel in the compare stage, would overflow. The store comes
// out of reset reading all zero with no clearing pass: a fill mark tracks the
// positions written so far. csr_ready is always high; write frame_base and
// frame_pixels only while no pixel is in flight.
// ----------------------------------------------------------------------------
module frame_diff_write_emitter import fdw_pkg::*; #(
   parameter int MAX_PIXELS = 1048576
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_new_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ADDR_W-1:0]      rsp_write_address,
   output logic [PIXEL_W-1:0]     rsp_pixel_value,
   output logic                   rsp_run_start,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [ADDR_W-1:0]         frame_base_ff;
   logic [FRAME_PIXELS_W-1:0] frame_pixels_ff;

   logic                      req_accept, rsp_accept;
   logic                      wr_valid, front_busy;
   fdw_write_type             wr_word, head_word;
   logic [QUEUE_LEVEL_W-1:0]  queue_level;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff   <= '0;
         frame_pixels_ff <= FRAME_PIXELS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_BASE:   frame_base_ff   <= csr_data[ADDR_W-1:0];
            CSR_FRAME_PIXELS: frame_pixels_ff <= csr_data[FRAME_PIXELS_W-1:0];
            default: ;
         endcase
      end
   end

   // hold input while the queue, counting the word now in compare, would be full
   assign req_stall  = (queue_level + QUEUE_LEVEL_W'(front_busy))
                       >= QUEUE_LEVEL_W'(QUEUE_DEPTH);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   fdw_front #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .frame_base   (frame_base_ff),
      .frame_pixels (frame_pixels_ff),
      .in_accept    (req_accept),
      .in_pixel     (req_new_pixel),
      .wr_valid     (wr_valid),
      .wr_word      (wr_word),
      .busy         (front_busy)
   );

   fdw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (wr_valid),
      .push_word (wr_word),
      .pop       (rsp_accept),
      .out_valid (rsp_valid),
      .out_word  (head_word),
      .level     (queue_level)
   );

   assign rsp_write_address = head_word.write_address;
   assign rsp_pixel_value   = head_word.pixel_value;
   assign rsp_run_start     = head_word.run_start;

endmodule

### hdl/fdw_front.sv
// ----------------------------------------------------------------------------
// fdw_front
// Raster position tracking, shown-frame store and change detection. Stage 0
// takes a pixel and reads the store; stage 1 compares, writes the store back
// and forms the framebuffer write word for a changed pixel.
// ----------------------------------------------------------------------------
module fdw_front import fdw_pkg::*; #(
   parameter int MAX_PIXELS = 1048576
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [ADDR_W-1:0]         frame_base,
   input  logic [FRAME_PIXELS_W-1:0] frame_pixels,
   input  logic                      in_accept,
   input  logic [PIXEL_W-1:0]        in_pixel,
   output logic                      wr_valid,
   output fdw_write_type             wr_word,
   output logic                      busy
);

   localparam int POS_W  = $clog2(MAX_PIXELS);
   localparam int CNT_W0 = $clog2(MAX_PIXELS + 1);
   localparam int CNT_W  = (CNT_W0 > FRAME_PIXELS_W) ? CNT_W0 : FRAME_PIXELS_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);

   logic [PIXEL_W-1:0] store_mem [MAX_PIXELS];

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               run_ff, run_in;
   logic [CNT_W-1:0]   fill_ff;
   logic [PIXEL_W-1:0] rd_data_ff;

   logic               s1_valid_ff;
   logic [POS_W-1:0]   s1_pos_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic               s1_clr_ff;
   logic               s1_last_ff;
   logic               s1_filled_ff;

   logic               fwd_valid_ff;
   logic [POS_W-1:0]   fwd_pos_ff;
   logic [PIXEL_W-1:0] fwd_pixel_ff;

   logic [CNT_W-1:0]   pixels_ext, frame_size, next_ext;
   logic               past_end, frame_last;
   logic [POS_W-1:0]   eff_pos;
   logic               fwd_hit, changed, run_now;
   logic [PIXEL_W-1:0] old_pixel;

   // stage 0: position with wrap
   always_comb begin
      pixels_ext = CNT_W'(frame_pixels);
      frame_size = (pixels_ext == '0 || pixels_ext > MAX_CNT) ? MAX_CNT : pixels_ext;
      past_end   = CNT_W'(pos_ff) >= frame_size;
      eff_pos    = past_end ? '0 : pos_ff;
      next_ext   = CNT_W'(eff_pos) + CNT_W'(1);
      frame_last = next_ext >= frame_size;
      pos_in     = frame_last ? '0 : next_ext[POS_W-1:0];
   end

   // stage 1: compare against the store, forwarding the previous write
   always_comb begin
      fwd_hit   = fwd_valid_ff && (fwd_pos_ff == s1_pos_ff);
      old_pixel = fwd_hit ? fwd_pixel_ff : (s1_filled_ff ? rd_data_ff : '0);
      changed   = old_pixel != s1_pixel_ff;
      run_now   = s1_clr_ff ? 1'b0 : run_ff;
      run_in    = s1_last_ff ? 1'b0 : changed;
   end

   // every pixel is written back, so the written entries always form a prefix
   always_ff @(posedge clock) begin
      if (in_accept) begin
         rd_data_ff <= store_mem[eff_pos];
      end
      if (s1_valid_ff) begin
         store_mem[s1_pos_ff] <= s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         run_ff       <= 1'b0;
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_accept;
         if (in_accept) begin
            pos_ff <= pos_in;
         end
         if (s1_valid_ff) begin
            run_ff       <= run_in;
            fwd_valid_ff <= 1'b1;
            if (CNT_W'(s1_pos_ff) == fill_ff) begin
               fill_ff <= fill_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         s1_pos_ff    <= eff_pos;
         s1_pixel_ff  <= in_pixel;
         s1_clr_ff    <= past_end;
         s1_last_ff   <= frame_last;
         s1_filled_ff <= CNT_W'(eff_pos) < fill_ff;
      end
      if (s1_valid_ff) begin
         fwd_pos_ff   <= s1_pos_ff;
         fwd_pixel_ff <= s1_pixel_ff;
      end
   end

   always_comb begin
      wr_valid              = s1_valid_ff && changed;
      wr_word.write_address = frame_base + (ADDR_W'(s1_pos_ff) << 2);
      wr_word.pixel_value   = s1_pixel_ff;
      wr_word.run_start     = !run_now;
      busy                  = s1_valid_ff;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= MAX_CNT)
      else $error("store fill mark beyond store depth");

   a_fill_prefix: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> CNT_W'(s1_pos_ff) <= fill_ff)
      else $error("store access skips past the fill mark");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff |=> !run_ff)
      else $error("changed run carried across a frame wrap");

endmodule

### hdl/fdw_queue.sv
// ----------------------------------------------------------------------------
// fdw_queue
// Short queue of framebuffer write words between change detection and the
// result channel; the head entry drives the result ports.
// ----------------------------------------------------------------------------
module fdw_queue import fdw_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  fdw_write_type            push_word,
   input  logic                     pop,
   output logic                     out_valid,
   output fdw_write_type            out_word,
   output logic [QUEUE_LEVEL_W-1:0] level
);

   fdw_write_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   head_ff, tail_ff;
   logic [QUEUE_LEVEL_W-1:0] level_ff;
   logic                     do_pop;

   assign do_pop    = pop && (level_ff != '0);
   assign out_valid = level_ff != '0;
   assign out_word  = slot_ff[head_ff];
   assign level     = level_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= tail_ff + QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            head_ff <= head_ff + QUEUE_PTR_W'(1);
         end
         case ({push, do_pop})
            2'b10:   level_ff <= level_ff + QUEUE_LEVEL_W'(1);
            2'b01:   level_ff <= level_ff - QUEUE_LEVEL_W'(1);
            default: level_ff <= level_ff;
         endcase
      end
   end

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= QUEUE_LEVEL_W'(QUEUE_DEPTH))
      else $error("queue level beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> level_ff != QUEUE_LEVEL_W'(QUEUE_DEPTH))
      else $error("write word pushed into a full queue");

endmodule
